@@ rtl/frp_pkg.sv @@
// Package: shared types and constants for the forest root position core.
`timescale 1ns / 1ps
package frp_pkg;

  localparam int unsigned POS_W = 63;
  localparam int unsigned HGT_W = 6;
  localparam logic [HGT_W-1:0] MAX_FH = HGT_W'(62);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } frp_state_t;

  // Result of one scan step
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] sh_nxt;
    logic [POS_W-1:0] fill_nxt;
    logic             last;
  } frp_step_t;

endpackage

@@ rtl/forest_root_positions_core.sv @@
// Top level: root positions of the perfect subtrees of a forest, one result per set count bit.
`timescale 1ns / 1ps
// Accepts a leaf count and emits one beat per set bit of the count (masked to
// forest_height+1 bits), lowest tree height first, with out_last_root on the
// highest one; a zero count gives no beats. A single step unit walks the count
// one bit per cycle, stalling while the result register waits on out_ready, and
// the block takes no new count until the walk ends; in_ready is low throughout.
// forest_height is written via cfg_we/cfg_wdata; values above 62 act as 62. The
// user must write it only while idle; the block itself does not enforce this.
module forest_root_positions_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [frp_pkg::HGT_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [frp_pkg::POS_W-1:0] in_leaf_count,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [frp_pkg::POS_W-1:0] out_root_position,
  output logic [frp_pkg::HGT_W-1:0] out_tree_height,
  output logic                      out_last_root
);
  import frp_pkg::*;

  frp_state_t       state_r, state_nxt;
  logic [HGT_W-1:0] fh_r;
  logic [POS_W-1:0] mask_r;
  logic [POS_W-1:0] top_r;
  logic [POS_W-1:0] sh_r;
  logic [POS_W-1:0] fill_r;
  logic [HGT_W-1:0] h_r;
  logic             out_valid_r;
  logic [POS_W-1:0] out_pos_r;
  logic [HGT_W-1:0] out_height_r;
  logic             out_last_r;

  logic             in_acc;
  logic             out_free;
  logic             emit;
  logic             advance;
  logic [HGT_W-1:0] fh_clamp;
  frp_step_t        step;

  // Shared step unit
  frp_step u_step (
    .sh   (sh_r),
    .fill (fill_r),
    .top  (top_r),
    .res  (step)
  );

  // Configuration: clamp height, precompute field mask and top fill bit
  assign fh_clamp = (cfg_wdata > MAX_FH) ? MAX_FH : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fh_r   <= '0;
      mask_r <= POS_W'(1);
      top_r  <= POS_W'(1);
    end else if (cfg_we) begin
      fh_r   <= fh_clamp;
      mask_r <= {POS_W{1'b1}} >> (MAX_FH - fh_clamp);
      top_r  <= POS_W'(1) << fh_clamp;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RUN;
      ST_RUN:  if (advance && step.last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = 1'b0;
    advance  = 1'b0;
    emit     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN: begin
        emit    = sh_r[0] && out_free;
        advance = !sh_r[0] || out_free;
      end
      default: ;
    endcase
  end

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Scan registers: count shifted right by h, upper fill, height
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sh_r   <= in_leaf_count & mask_r;
      fill_r <= '0;
      h_r    <= '0;
    end else if (advance) begin
      sh_r   <= step.sh_nxt;
      fill_r <= step.fill_nxt;
      h_r    <= h_r + HGT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pos_r    <= step.pos;
      out_height_r <= h_r;
      out_last_r   <= step.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_root_position = out_pos_r;
  assign out_tree_height   = out_height_r;
  assign out_last_root     = out_last_r;

  // Checks
  a_h_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (h_r <= fh_r))
    else $error("scan height past forest height");

  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RUN) && (h_r == '0) && (fill_r == '0))
    else $error("scan not restarted on accept");

  a_emit_beat: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r && (out_height_r == $past(h_r)))
    else $error("emitted beat missing or wrong height");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !emit)
    else $error("result overwritten while stalled");

  a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ((sh_r & ~mask_r) == '0))
    else $error("count bits outside forest field");

endmodule

@@ rtl/frp_step.sv @@
// Scan step unit: forms one root position and advances the count shift and upper fill.
`timescale 1ns / 1ps
module frp_step (
  input  logic [frp_pkg::POS_W-1:0] sh,
  input  logic [frp_pkg::POS_W-1:0] fill,
  input  logic [frp_pkg::POS_W-1:0] top,
  output frp_pkg::frp_step_t        res
);
  import frp_pkg::*;

  // sh holds count >> h; the start offset >> h is that with bit 0 cleared
  assign res.pos      = {sh[POS_W-1:1], 1'b0} | fill;
  // no higher count bits left means this is the highest root
  assign res.last     = (sh[POS_W-1:1] == '0);
  assign res.sh_nxt   = {1'b0, sh[POS_W-1:1]};
  // one more ones bit enters below the ones already at the top of the field
  assign res.fill_nxt = {1'b0, fill[POS_W-1:1]} | top;

endmodule

@@ bench/testbench.sv @@
// Testbench: self-checking regression for the forest root position core.
`timescale 1ns / 1ps
module testbench;
  import frp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 70;           // longest walk of one count plus margin
  localparam longint unsigned RUN_LIMIT_NS = 10_000_000;

  // One expected root beat
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [HGT_W-1:0] hgt;
    logic             last;
  } root_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [HGT_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [POS_W-1:0] in_leaf_count = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [POS_W-1:0] out_root_position;
  logic [HGT_W-1:0] out_tree_height;
  logic             out_last_root;

  logic             steady = 1'b0;    // no idling on either side while set
  logic [HGT_W-1:0] forest_h = '0;    // last forest height written, before the clamp
  root_beat_t       pending_roots[$];
  int               mismatch_count = 0;
  int               counts_sent = 0;
  int               roots_checked = 0;
  int               heights_written = 0;

  forest_root_positions_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_leaf_count     (in_leaf_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_root_position (out_root_position),
    .out_tree_height   (out_tree_height),
    .out_last_root     (out_last_root)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout: core stopped making progress");
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] root mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Expected root beats for one accepted count under the current forest height
  function automatic void predict_roots(input logic [POS_W-1:0] leaf_count);
    logic [63:0] fh;
    logic [63:0] mask;
    logic [63:0] cnt;
    logic [63:0] start;
    logic [63:0] fill;
    logic [63:0] pos;
    int          top;
    root_beat_t  beat;
    fh = (forest_h > MAX_FH) ? 64'(MAX_FH) : 64'(forest_h);
    mask = (64'd2 << fh) - 64'd1;
    cnt = {1'b0, leaf_count} & mask;
    top = -1;
    for (int h = 0; h <= int'(fh); h++) begin
      if (cnt[h]) top = h;
    end
    for (int h = 0; h <= int'(fh); h++) begin
      if (cnt[h]) begin
        // offset where this tree starts, climbed h levels, upper bits filled
        start = cnt & ~((64'd2 << h) - 64'd1);
        fill = (mask << (fh + 64'd1 - 64'(h))) & mask;
        pos = ((start >> h) | fill) & mask;
        beat.pos = pos[POS_W-1:0];
        beat.hgt = HGT_W'(h);
        beat.last = (h == top);
        pending_roots = {pending_roots, beat};
      end
    end
  endfunction

  // Send one count beat; called and returns at a rising edge
  task automatic send_leaf_count(input logic [POS_W-1:0] value);
    while (!steady && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_leaf_count <= value;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_roots(value);
    counts_sent++;
  endtask

  // Hold off input until every expected root has arrived and the core is idle
  task automatic wait_roots_done();
    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_forest_height(input logic [HGT_W-1:0] value);
    wait_roots_done();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    forest_h = value;
    heights_written++;
  endtask

  // Mix of full random, sparse, dense and small counts
  function automatic logic [POS_W-1:0] rand_leaf_count();
    logic [POS_W-1:0] v;
    v = POS_W'({$urandom, $urandom});
    case ($urandom_range(3))
      0: ;
      1: v = (POS_W'(1) << $urandom_range(62)) | (POS_W'(1) << $urandom_range(62));
      2: v = ~(POS_W'(1) << $urandom_range(62)) & ~(POS_W'(1) << $urandom_range(62));
      default: v = v & ((POS_W'(1) << $urandom_range(1, 8)) - POS_W'(1));
    endcase
    return v;
  endfunction

  // Receiver side: random back-pressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 7);
  end

  // Compare each root beat with the oldest expectation
  always @(posedge clk) begin : check_roots
    root_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_roots.size() == 0) begin
        report_mismatch($sformatf("unexpected beat pos=%h height=%0d last=%0b",
                                  out_root_position, out_tree_height, out_last_root));
      end else begin
        want = pending_roots.pop_front();
        if (out_root_position !== want.pos)
          report_mismatch($sformatf("position got %h want %h (height %0d)",
                                    out_root_position, want.pos, want.hgt));
        if (out_tree_height !== want.hgt)
          report_mismatch($sformatf("height got %0d want %0d", out_tree_height, want.hgt));
        if (out_last_root !== want.last)
          report_mismatch($sformatf("last flag got %0b want %0b (height %0d)",
                                    out_last_root, want.last, want.hgt));
        roots_checked++;
      end
    end
  end

  // Height zero from reset: only count bit 0 matters
  task automatic test_reset_height();
    send_leaf_count('0);
    send_leaf_count(POS_W'(1));
    send_leaf_count(POS_W'(2));
    send_leaf_count('1);
  endtask

  // Full height: extremes of the count, alternating patterns, single bits
  task automatic test_extremes();
    set_forest_height(MAX_FH);
    send_leaf_count('0);
    send_leaf_count(POS_W'(1));
    send_leaf_count(POS_W'(1) << 62);
    send_leaf_count('1);
    send_leaf_count({32{2'b01}});
    send_leaf_count({32{2'b10}});
    send_leaf_count(POS_W'(1) << 30);
    send_leaf_count(POS_W'(3));
  endtask

  // Register value above range acts as the top height
  task automatic test_height_clamp();
    set_forest_height('1);
    send_leaf_count('1);
    send_leaf_count(POS_W'(1) << 62);
    send_leaf_count(POS_W'(5));
  endtask

  // Sender waits for every expected root before the next count
  task automatic test_drain_pause();
    set_forest_height(HGT_W'(5));
    for (int i = 0; i < 4; i++) begin
      send_leaf_count(rand_leaf_count());
      wait_roots_done();
    end
  endtask

  // Random counts across a spread of heights, one phase with no idling
  task automatic test_random_heights();
    logic [HGT_W-1:0] heights[8];
    heights = '{HGT_W'(0), HGT_W'(1), HGT_W'(2), HGT_W'(17), HGT_W'(31),
                MAX_FH, HGT_W'(63), HGT_W'($urandom_range(3, 61))};
    foreach (heights[p]) begin
      set_forest_height(heights[p]);
      steady <= (heights[p] == MAX_FH);
      repeat (42) send_leaf_count(rand_leaf_count());
    end
    steady <= 1'b0;
  endtask

  // Test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_height();
    test_extremes();
    test_height_clamp();
    test_drain_pause();
    test_random_heights();
    wait_roots_done();
    $display("Sent %0d leaf counts under %0d forest height writes, checked %0d root beats",
             counts_sent, heights_written, roots_checked);
    $display("Covered zero and full counts, ignored high bits and the clamped height");
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
